FILE: rtl/wlvc_pkg.sv
`timescale 1ns / 1ps

package wlvc_pkg;

  localparam int unsigned SpeedW = 8;
  localparam int unsigned RawW   = 16;
  localparam int unsigned LevelW = 7;
  localparam int unsigned PhaseW = 16;
  localparam int unsigned CfgW   = 8;

  localparam logic [SpeedW-1:0] HystBand = 8'd10;
  localparam logic [LevelW-1:0] LevelMax = 7'd100;

  typedef enum logic [0:0] {
    CfgSpeedThreshold = 1'b0,
    CfgLedLowLevel    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [LevelW-1:0] led_brightness;
    logic              motor_on;
    logic              lockout_active;
  } result_t;

endpackage

FILE: rtl/warning_led_and_vibration_control_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
// in      | in        | in_valid_i/in_ready_o | feature_enable_i, speed_raw_i, position_lamp_i,
//         |           |                       | ack_pressed_i, level3_warning_i
// out     | out       | out_valid_o/out_ready_i | led_brightness_o, motor_on_o, lockout_active_o
//
// One word per cycle unless the output stalls: the state update and the result are
// computed in one pass from the input port and the state registers, and land in the
// output register, which is loaded on acceptance; a full output register that is
// being drained still takes a new word. Reset clears state, config and valid.

module warning_led_and_vibration_control_top #(
  parameter int unsigned PULSE_PERIOD   = 8,
  parameter int unsigned PULSE_ON_TICKS = 6,
  parameter int unsigned MIN_PERIODS    = 2,
  parameter int unsigned LOCKOUT_TICKS  = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [wlvc_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        feature_enable_i,
  input  logic [wlvc_pkg::RawW-1:0]   speed_raw_i,
  input  logic                        position_lamp_i,
  input  logic                        ack_pressed_i,
  input  logic                        level3_warning_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [wlvc_pkg::LevelW-1:0] led_brightness_o,
  output logic                        motor_on_o,
  output logic                        lockout_active_o
);
  import wlvc_pkg::*;

  localparam int unsigned EffPeriod = (PULSE_PERIOD == 0) ? 1 : PULSE_PERIOD;
  localparam int unsigned ModW = (EffPeriod > 1) ? $clog2(EffPeriod) : 1;
  localparam int unsigned DivW = (MIN_PERIODS > 0) ? $clog2(MIN_PERIODS + 1) : 1;
  localparam int unsigned LockW = $clog2(LOCKOUT_TICKS + 1);

  logic [SpeedW-1:0] thr_q;
  logic [LevelW-1:0] low_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ModW-1:0]   mod_q, mod_d;
  logic [DivW-1:0]   div_q, div_d;
  logic              armed_q, armed_d;
  logic [LockW-1:0]  lock_q, lock_d;
  logic [LevelW-1:0] led_q, led_d;
  logic              out_valid_q;
  result_t           res_d, res_q;
  logic              in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  wlvc_step #(
    .PULSE_PERIOD  (PULSE_PERIOD),
    .PULSE_ON_TICKS(PULSE_ON_TICKS),
    .MIN_PERIODS   (MIN_PERIODS),
    .LOCKOUT_TICKS (LOCKOUT_TICKS)
  ) u_step (
    .speed_threshold_i(thr_q),
    .led_low_level_i  (low_q),
    .feature_enable_i (feature_enable_i),
    .speed_raw_i      (speed_raw_i),
    .position_lamp_i  (position_lamp_i),
    .ack_pressed_i    (ack_pressed_i),
    .level3_warning_i (level3_warning_i),
    .phase_i          (phase_q),
    .phase_mod_i      (mod_q),
    .phase_div_i      (div_q),
    .armed_i          (armed_q),
    .lock_cnt_i       (lock_q),
    .led_level_i      (led_q),
    .phase_o          (phase_d),
    .phase_mod_o      (mod_d),
    .phase_div_o      (div_d),
    .armed_o          (armed_d),
    .lock_cnt_o       (lock_d),
    .led_level_o      (led_d),
    .result_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      low_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgSpeedThreshold: thr_q <= cfg_data_i[SpeedW-1:0];
        CfgLedLowLevel:    low_q <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      mod_q       <= '0;
      div_q       <= '0;
      armed_q     <= 1'b0;
      lock_q      <= '0;
      led_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        mod_q   <= mod_d;
        div_q   <= div_d;
        armed_q <= armed_d;
        lock_q  <= lock_d;
        led_q   <= led_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_brightness_o = res_q.led_brightness;
  assign motor_on_o       = res_q.motor_on;
  assign lockout_active_o = res_q.lockout_active;

endmodule

FILE: rtl/wlvc_step.sv
`timescale 1ns / 1ps

module wlvc_step #(
  parameter int unsigned PULSE_PERIOD   = 8,
  parameter int unsigned PULSE_ON_TICKS = 6,
  parameter int unsigned MIN_PERIODS    = 2,
  parameter int unsigned LOCKOUT_TICKS  = 24,
  localparam int unsigned EffPeriod = (PULSE_PERIOD == 0) ? 1 : PULSE_PERIOD,
  localparam int unsigned ModW = (EffPeriod > 1) ? $clog2(EffPeriod) : 1,
  localparam int unsigned DivW = (MIN_PERIODS > 0) ? $clog2(MIN_PERIODS + 1) : 1,
  localparam int unsigned LockW = $clog2(LOCKOUT_TICKS + 1)
) (
  input  logic [wlvc_pkg::SpeedW-1:0] speed_threshold_i,
  input  logic [wlvc_pkg::LevelW-1:0] led_low_level_i,
  input  logic                        feature_enable_i,
  input  logic [wlvc_pkg::RawW-1:0]   speed_raw_i,
  input  logic                        position_lamp_i,
  input  logic                        ack_pressed_i,
  input  logic                        level3_warning_i,
  input  logic [wlvc_pkg::PhaseW-1:0] phase_i,
  input  logic [ModW-1:0]             phase_mod_i,
  input  logic [DivW-1:0]             phase_div_i,
  input  logic                        armed_i,
  input  logic [LockW-1:0]            lock_cnt_i,
  input  logic [wlvc_pkg::LevelW-1:0] led_level_i,
  output logic [wlvc_pkg::PhaseW-1:0] phase_o,
  output logic [ModW-1:0]             phase_mod_o,
  output logic [DivW-1:0]             phase_div_o,
  output logic                        armed_o,
  output logic [LockW-1:0]            lock_cnt_o,
  output logic [wlvc_pkg::LevelW-1:0] led_level_o,
  output wlvc_pkg::result_t           result_o
);
  import wlvc_pkg::*;

  localparam int unsigned EffDuty = (PULSE_ON_TICKS >= EffPeriod) ? EffPeriod : PULSE_ON_TICKS;
  localparam logic [ModW:0]    DutyC    = EffDuty[ModW:0];
  localparam logic [ModW-1:0]  ModLast  = ModW'(EffPeriod - 1);
  localparam logic [DivW-1:0]  DivSat   = DivW'(MIN_PERIODS);
  localparam logic [LockW-1:0] LockLoad = LockW'(LOCKOUT_TICKS);

  logic [SpeedW-1:0] speed;
  logic [SpeedW-1:0] lower;
  logic [LevelW-1:0] low_sat;
  logic              locked;
  logic              start_lock;
  logic              motor;
  logic              tick;
  logic              clear;
  logic [DivW-1:0]   need;
  logic              tick_on;
  logic [PhaseW-1:0] ph_inc;
  logic [ModW-1:0]   mod_inc;
  logic [DivW-1:0]   div_inc;

  assign speed   = speed_raw_i[RawW-1:RawW-SpeedW];
  assign lower   = (speed_threshold_i > HystBand) ? speed_threshold_i - HystBand : '0;
  assign low_sat = (led_low_level_i > LevelMax) ? LevelMax : led_low_level_i;
  assign locked  = (lock_cnt_i != '0);
  assign need    = armed_i ? DivSat : '0;

  // wrap of the 16-bit phase restarts the period position and count
  assign tick_on = ({1'b0, phase_mod_i} < DutyC);
  assign ph_inc  = phase_i + 1'b1;
  always_comb begin
    if (phase_i == '1) begin
      mod_inc = '0;
      div_inc = '0;
    end else if (phase_mod_i == ModLast) begin
      mod_inc = '0;
      div_inc = (phase_div_i == DivSat) ? phase_div_i : phase_div_i + 1'b1;
    end else begin
      mod_inc = phase_mod_i + 1'b1;
      div_inc = phase_div_i;
    end
  end

  always_comb begin
    led_level_o = led_level_i;
    armed_o     = armed_i;
    start_lock  = 1'b0;
    tick        = 1'b0;
    clear       = 1'b0;
    if (feature_enable_i) begin
      if (speed < lower) begin
        led_level_o = '0;
      end else if (speed > speed_threshold_i) begin
        led_level_o = position_lamp_i ? low_sat : LevelMax;
      end
      if (!ack_pressed_i && !locked) begin
        if (level3_warning_i) begin
          tick    = 1'b1;
          armed_o = 1'b1;
        end else if (phase_i != '0 && phase_div_i < need) begin
          tick = 1'b1;
        end else begin
          clear   = 1'b1;
          armed_o = 1'b0;
        end
      end else begin
        clear      = 1'b1;
        start_lock = ack_pressed_i && !locked;
      end
    end else begin
      led_level_o = '0;
      clear       = 1'b1;
    end
  end

  always_comb begin
    motor       = 1'b0;
    phase_o     = phase_i;
    phase_mod_o = phase_mod_i;
    phase_div_o = phase_div_i;
    if (tick) begin
      motor       = tick_on;
      phase_o     = ph_inc;
      phase_mod_o = mod_inc;
      phase_div_o = div_inc;
    end else if (clear) begin
      phase_o     = '0;
      phase_mod_o = '0;
      phase_div_o = '0;
    end
  end

  always_comb begin
    lock_cnt_o = locked ? lock_cnt_i - 1'b1 : lock_cnt_i;
    if (start_lock) begin
      lock_cnt_o = LockLoad;
    end
  end

  assign result_o.led_brightness = led_level_o;
  assign result_o.motor_on       = motor;
  assign result_o.lockout_active = (lock_cnt_o != '0);

endmodule

FILE: tb/sv/wlvc_drive_checker.sv
`timescale 1ns / 1ps

module wlvc_drive_checker #(
  parameter int unsigned PULSE_PERIOD   = 8,
  parameter int unsigned PULSE_ON_TICKS = 6,
  parameter int unsigned MIN_PERIODS    = 2,
  parameter int unsigned LOCKOUT_TICKS  = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [wlvc_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        feature_enable_i,
  input  logic [wlvc_pkg::RawW-1:0]   speed_raw_i,
  input  logic                        position_lamp_i,
  input  logic                        ack_pressed_i,
  input  logic                        level3_warning_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [wlvc_pkg::LevelW-1:0] led_brightness_i,
  input  logic                        motor_on_i,
  input  logic                        lockout_active_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);
  import wlvc_pkg::*;

  localparam int unsigned Period = (PULSE_PERIOD == 0) ? 1 : PULSE_PERIOD;
  localparam int unsigned Duty   = (PULSE_ON_TICKS >= Period) ? Period : PULSE_ON_TICKS;

  logic [SpeedW-1:0] threshold;
  logic [LevelW-1:0] low_level;
  logic [PhaseW-1:0] phase;
  logic              hold_armed;
  logic [7:0]        lock_left;
  logic [LevelW-1:0] led_held;
  result_t           drive_queue[$];

  task automatic pulse_step(output logic on);
    on = (phase % Period) < Duty;
    phase = phase + 1'b1;
  endtask

  task automatic step_controller(input logic en, input logic [RawW-1:0] raw,
                                 input logic lamp, input logic ack, input logic warn,
                                 output result_t res);
    logic [SpeedW-1:0] speed;
    logic [SpeedW-1:0] lower;
    logic              locked;
    logic              start_lock;
    logic              motor;
    int unsigned       need;
    speed      = raw[RawW-1:RawW-SpeedW];
    locked     = lock_left != 0;
    start_lock = 1'b0;
    motor      = 1'b0;
    if (en) begin
      lower = (threshold > HystBand) ? threshold - HystBand : '0;
      if (speed < lower) begin
        led_held = '0;
      end else if (speed > threshold) begin
        if (lamp) begin
          led_held = (low_level > LevelMax) ? LevelMax : low_level;
        end else begin
          led_held = LevelMax;
        end
      end
      if (!ack && !locked) begin
        if (warn) begin
          pulse_step(motor);
          hold_armed = 1'b1;
        end else begin
          need = hold_armed ? MIN_PERIODS : 0;
          if (phase != 0 && (phase / Period) < need) begin
            pulse_step(motor);
          end else begin
            phase      = '0;
            hold_armed = 1'b0;
          end
        end
      end else begin
        phase      = '0;
        start_lock = ack && !locked;
      end
    end else begin
      led_held = '0;
      phase    = '0;
    end
    if (locked) lock_left = lock_left - 1'b1;
    if (start_lock) lock_left = 8'(LOCKOUT_TICKS);
    res.led_brightness = led_held;
    res.motor_on       = motor;
    res.lockout_active = lock_left != 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      threshold        = '0;
      low_level        = '0;
      phase            = '0;
      hold_armed       = 1'b0;
      lock_left        = '0;
      led_held         = '0;
      drive_queue.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      checked_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CfgSpeedThreshold: threshold = cfg_data_i;
          CfgLedLowLevel:    low_level = cfg_data_i[LevelW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.led_brightness = led_brightness_i;
        got.motor_on       = motor_on_i;
        got.lockout_active = lockout_active_i;
        if (drive_queue.size() == 0) begin
          $error("unexpected word: led %0d motor %0b lockout %0b",
                 got.led_brightness, got.motor_on, got.lockout_active);
          mismatch_count_o++;
        end else begin
          want = drive_queue.pop_front();
          checked_o++;
          if (got.led_brightness !== want.led_brightness) begin
            $error("led_brightness: expected %0d, got %0d",
                   want.led_brightness, got.led_brightness);
            mismatch_count_o++;
          end
          if (got.motor_on !== want.motor_on) begin
            $error("motor_on: expected %0b, got %0b", want.motor_on, got.motor_on);
            mismatch_count_o++;
          end
          if (got.lockout_active !== want.lockout_active) begin
            $error("lockout_active: expected %0b, got %0b",
                   want.lockout_active, got.lockout_active);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_controller(feature_enable_i, speed_raw_i, position_lamp_i, ack_pressed_i,
                        level3_warning_i, want);
        drive_queue.push_back(want);
      end
      pending_o = drive_queue.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import wlvc_pkg::*;

  localparam int unsigned Limit = 200000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [0:0]        cfg_idx;
  logic [CfgW-1:0]   cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              feature_enable;
  logic [RawW-1:0]   speed_raw;
  logic              position_lamp;
  logic              ack_pressed;
  logic              level3_warning;
  logic              out_valid;
  logic              out_ready;
  logic [LevelW-1:0] led_brightness;
  logic              motor_on;
  logic              lockout_active;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles;
  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned gap_pct;
  int unsigned stall_pct;
  logic        calm;
  logic [SpeedW-1:0] thr_now;
  logic        warn_level;
  int unsigned warn_run;

  warning_led_and_vibration_control_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .feature_enable_i (feature_enable),
    .speed_raw_i      (speed_raw),
    .position_lamp_i  (position_lamp),
    .ack_pressed_i    (ack_pressed),
    .level3_warning_i (level3_warning),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .led_brightness_o (led_brightness),
    .motor_on_o       (motor_on),
    .lockout_active_o (lockout_active)
  );

  wlvc_drive_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .feature_enable_i (feature_enable),
    .speed_raw_i      (speed_raw),
    .position_lamp_i  (position_lamp),
    .ack_pressed_i    (ack_pressed),
    .level3_warning_i (level3_warning),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .led_brightness_i (led_brightness),
    .motor_on_i       (motor_on),
    .lockout_active_i (lockout_active),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("FAIL warning_led_and_vibration_control_top");
      $finish;
    end
  end

  // receiver side: random stall bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // caller is at a falling edge
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we   = 1'b0;
    if (idx == CfgSpeedThreshold) thr_now = data;
  endtask

  task automatic send_tick(input logic en, input logic [RawW-1:0] raw, input logic lamp,
                           input logic ack, input logic warn);
    @(negedge clk);
    in_valid       = 1'b1;
    feature_enable = en;
    speed_raw      = raw;
    position_lamp  = lamp;
    ack_pressed    = ack;
    level3_warning = warn;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk);
    end
  endtask

  // leaves the caller at a falling edge with nothing outstanding
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_tick();
    int          sp;
    logic [RawW-1:0] raw;
    if (warn_run == 0) begin
      warn_level = ~warn_level;
      warn_run   = warn_level ? $urandom_range(1, 30) : $urandom_range(1, 20);
    end
    warn_run--;
    if ($urandom_range(0, 1) == 1) begin
      sp = int'(thr_now) + int'($urandom_range(0, 18)) - 14;
      if (sp < 0) sp = 0;
      if (sp > 255) sp = 255;
      raw = {sp[7:0], 8'($urandom)};
    end else begin
      raw = 16'($urandom);
    end
    send_tick($urandom_range(0, 19) != 0, raw, 1'($urandom), $urandom_range(0, 24) == 0,
              warn_level ^ ($urandom_range(0, 29) == 0));
  endtask

  task automatic random_phase(input logic [CfgW-1:0] thr, input logic [CfgW-1:0] low,
                              input int unsigned n, input int unsigned gp,
                              input int unsigned sp);
    write_reg(CfgSpeedThreshold, thr);
    write_reg(CfgLedLowLevel, low);
    settings_used++;
    gap_pct   = gp;
    stall_pct = sp;
    for (int unsigned i = 0; i < n; i++) begin
      random_tick();
      if (i == n / 2 && gp > 20) drain();
    end
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CfgSpeedThreshold;
    cfg_data       = '0;
    in_valid       = 1'b0;
    feature_enable = 1'b0;
    speed_raw      = '0;
    position_lamp  = 1'b0;
    ack_pressed    = 1'b0;
    level3_warning = 1'b0;
    calm           = 1'b0;
    gap_pct        = 0;
    stall_pct      = 0;
    thr_now        = '0;
    warn_level     = 1'b0;
    warn_run       = 0;
    cycles         = 0;
    ticks_sent     = 0;
    settings_used  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // hysteresis, lamp level, pulse pattern, minimum hold, ack lockout
    write_reg(CfgSpeedThreshold, 8'd50);
    write_reg(CfgLedLowLevel, 8'd30);
    settings_used++;
    gap_pct   = 10;
    stall_pct = 10;
    send_tick(1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 16'h3200, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 16'h28FF, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 16'h2700, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 16'h2D00, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 16'h3300, 1'b1, 1'b0, 1'b0);
    repeat (10) send_tick(1'b1, 16'h3000, 1'b1, 1'b0, 1'b1);
    repeat (7) send_tick(1'b1, 16'h3000, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 16'h3000, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 16'h3000, 1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 16'h3000, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 16'h3000, 1'b0, 1'b0, 1'b1);
    drain();

    // lower bound clipped at zero, low level saturating above one hundred
    write_reg(CfgSpeedThreshold, 8'd10);
    write_reg(CfgLedLowLevel, 8'hFF);
    settings_used++;
    send_tick(1'b1, 16'h0B00, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 16'h0000, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 16'h0A00, 1'b0, 1'b0, 1'b0);
    drain();

    random_phase(8'd0, 8'd0, 130, 0, 0);
    random_phase(8'd255, 8'd100, 130, 30, 30);
    random_phase(8'd11, 8'hFF, 130, 15, 15);
    random_phase(8'($urandom), 8'($urandom_range(0, 100)), 130, 35, 35);
    calm = 1'b1;
    random_phase(8'($urandom), 8'($urandom), 130, 0, 0);
    repeat (6) @(negedge clk);

    $display("Sent %0d ticks under %0d register settings; %0d words checked.",
             ticks_sent, settings_used, checked);
    $display("Covered LED hysteresis, lamp level, pulse hold and ack lockout paths.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS warning_led_and_vibration_control_top");
    end else begin
      $display("FAIL warning_led_and_vibration_control_top");
    end
    $finish;
  end

endmodule
